// ----- rtl/tthl_pkg.sv -----
// ----------------------------------------------------------------------------
// tthl_pkg: shared types and constants
// Action codes, register indices, reset values and the divider request.
// ----------------------------------------------------------------------------
package tthl_pkg;

  localparam int unsigned HistDepthDef = 16;
  localparam logic [31:0] SpanReset = 32'd3072;
  localparam logic [31:0] IntervalReset = 32'd307;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_SPAN     = 1'b0,
    CFG_INTERVAL = 1'b1
  } cfg_idx_t;

  // Divider request: start strobe with unsigned num and den; the quotient is truncated.
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;

endpackage

// ----- rtl/tthl_div.sv -----
// ----------------------------------------------------------------------------
// tthl_div: shared restoring divider
// One quotient bit per cycle; the numerator already holds the rounding bias.
// ----------------------------------------------------------------------------
module tthl_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tthl_pkg::div_req_t    req,
  output logic                  done,
  output logic [63:0]           quo
);
  import tthl_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [33:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    sh = {rem_r[32:0], q_r[63]};
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = busy_r && (cnt_r == 7'd1);
  assign quo = q_nxt;

endmodule

// ----- rtl/timestamped_track_history_lerp.sv -----
// ----------------------------------------------------------------------------
// timestamped_track_history_lerp: track history ring with lerp query
// Ring of timestamped positions; ticks age out and record, queries
// interpolate or extrapolate along the bracketing pair.
// ----------------------------------------------------------------------------
//  channel | ports                         | direction
//  in      | in_valid/in_stall, fields     | item into block
//  out     | out_valid/out_stall, fields   | one result beat per item
//  cfg     | cfg_we, cfg_index, cfg_data   | register writes
//
// Per item: a tick ages out expired entries one by one, then records; a query
// scans entries pairwise, then runs each axis through the shared divider (a
// single entry skips it). Clear, idle action or empty query go to the result.
// Reset clears count and pointer; ring contents are left as they are.
// in_stall is high whenever an item is in flight or its result waits.
// ----------------------------------------------------------------------------
module timestamped_track_history_lerp #(
  parameter int unsigned HISTORY_DEPTH = tthl_pkg::HistDepthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [31:0]                   in_time_stamp,
  input  logic                          in_target_present,
  input  logic signed [31:0]            in_live_x,
  input  logic signed [31:0]            in_live_y,
  input  logic signed [31:0]            in_live_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_pos_z,
  output logic                          out_target_lost,
  output logic [$clog2(HISTORY_DEPTH+1)-1:0] out_entry_count,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [31:0]                   cfg_data
);
  import tthl_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DROP  = 9'b000000010,
    S_NEWR  = 9'b000000100,
    S_NEWT  = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_AXIS  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_OUT   = 9'b010000000,
    S_RD    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // ring storage, one word per entry: {time, x, y, z}
  logic [127:0] mem [HISTORY_DEPTH];
  logic [127:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [31:0] span_r, intv_r;
  logic [AW-1:0] old_r, old_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] k_r, k_nxt;

  logic [1:0]  act_r;
  logic [31:0] t_r;
  logic        pres_r;
  logic [31:0] lx_r, ly_r, lz_r;

  logic [95:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [31:0] ta_r, ta_nxt, tb_r, tb_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic        neg_r, neg_nxt;
  logic signed [31:0] base_r, base_nxt;
  logic [31:0] px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic        lost_r, lost_nxt;
  logic        ov_r, ov_nxt;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dquo;

  logic [AW-1:0] kslot;
  logic [31:0]   rt;
  logic [32:0]   ext;
  logic [32:0]   diff, mdiff;
  logic [32:0]   dtv, mdt;
  logic [65:0]   prod;
  logic [32:0]   dur;
  logic signed [34:0] sumv;
  logic [31:0]   satv;
  logic          use_pair;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] d;
    d = v - (AW+1)'(HISTORY_DEPTH);
    return (v >= (AW+1)'(HISTORY_DEPTH)) ? d[AW-1:0] : v[AW-1:0];
  endfunction

  assign kslot = wrap({1'b0, old_r} + (AW+1)'(k_r[AW-1:0]));
  assign rd_addr = kslot;
  assign rt = rd_r[127:96];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= {t_r, lx_r, ly_r, lz_r};
    rd_r <= mem[rd_addr];
  end

  assign ext = {1'b0, t_r} - {1'b0, span_r};

  // one axis of the line: a pair selected by ax_r
  logic signed [31:0] av, bv;
  always_comb begin
    case (ax_r)
      2'd0: begin av = pa_r[95:64]; bv = pb_r[95:64]; end
      2'd1: begin av = pa_r[63:32]; bv = pb_r[63:32]; end
      default: begin av = pa_r[31:0]; bv = pb_r[31:0]; end
    endcase
    diff = {bv[31], bv} - {av[31], av};
    mdiff = diff[32] ? -diff : diff;
    dtv = {1'b0, t_r} - {1'b0, ta_r};
    mdt = dtv[32] ? -dtv : dtv;
    dur = {1'b0, tb_r} - {1'b0, ta_r};
    prod = mdiff * mdt;
    sumv = neg_r ? ({{3{base_r[31]}}, base_r} - {1'b0, dquo[33:0]})
                 : ({{3{base_r[31]}}, base_r} + {1'b0, dquo[33:0]});
    if (dquo > 64'h2_0000_0000)
      satv = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (sumv > 35'sh7FFF_FFFF)
      satv = 32'h7FFF_FFFF;
    else if (sumv < -35'sh8000_0000)
      satv = 32'h8000_0000;
    else
      satv = sumv[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    old_nxt = old_r;
    cnt_nxt = cnt_r;
    k_nxt = k_r;
    pa_nxt = pa_r; pb_nxt = pb_r; ta_nxt = ta_r; tb_nxt = tb_r;
    ax_nxt = ax_r;
    neg_nxt = neg_r;
    base_nxt = base_r;
    px_nxt = px_r; py_nxt = py_r; pz_nxt = pz_r;
    lost_nxt = lost_r;
    ov_nxt = ov_r;
    wr_en = 1'b0;
    wr_addr = wrap({1'b0, old_r} + (AW+1)'(cnt_r[AW-1:0]));
    dreq = '0;
    // entry k against entry k-1: bracketing pair, before the oldest entry
    // (times rise along the ring, so no later pair can bracket), or past the
    // newest entry on the last pair
    use_pair = (t_r >= ta_r && t_r <= rt) || (t_r >= rt && t_r <= ta_r) ||
               (k_r == CW'(1) && ta_r > t_r) ||
               (k_r + CW'(1) == cnt_r && t_r > rt);
    unique case (state_r)
      S_IDLE: begin
        k_nxt = '0;
        if (in_valid) begin
          px_nxt = '0; py_nxt = '0; pz_nxt = '0; lost_nxt = 1'b0;
          unique case (action_t'(in_action))
            ACT_TICK: state_nxt = S_RD;
            ACT_QUERY: begin
              if (cnt_r == '0) begin
                if (in_target_present) begin
                  px_nxt = in_live_x; py_nxt = in_live_y; pz_nxt = in_live_z;
                end
                state_nxt = S_OUT;
              end else
                state_nxt = S_RD;
            end
            ACT_CLEAR: begin
              old_nxt = '0; cnt_nxt = '0; state_nxt = S_OUT;
            end
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_RD: state_nxt = (act_r == ACT_TICK) ? S_DROP : S_SCAN;
      S_DROP: begin
        // rd_r holds the oldest entry
        if (cnt_r != '0 && !ext[32] && ext[31:0] > rt) begin
          old_nxt = wrap({1'b0, old_r} + (AW+1)'(1));
          cnt_nxt = cnt_r - CW'(1);
          state_nxt = S_RD;
        end else begin
          k_nxt = (cnt_r == '0) ? '0 : cnt_r - CW'(1);
          state_nxt = S_NEWR;
        end
      end
      S_NEWR: state_nxt = S_NEWT;
      S_NEWT: begin
        if (cnt_r == '0 || {1'b0, t_r} > {1'b0, rt} + {1'b0, intv_r}) begin
          if (pres_r) begin
            if (cnt_r == CW'(HISTORY_DEPTH)) begin
              wr_addr = old_r;
              old_nxt = wrap({1'b0, old_r} + (AW+1)'(1));
            end else
              cnt_nxt = cnt_r + CW'(1);
            wr_en = 1'b1;
          end else
            lost_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_SCAN: begin
        // rd_r holds entry k; ta_r/pa_r hold entry k-1
        if (cnt_r == CW'(1)) begin
          px_nxt = rd_r[95:64]; py_nxt = rd_r[63:32]; pz_nxt = rd_r[31:0];
          state_nxt = S_OUT;
        end else if (k_r == '0) begin
          ta_nxt = rt; pa_nxt = rd_r[95:0];
          k_nxt = CW'(1);
          state_nxt = S_RD;
        end else if (use_pair) begin
          tb_nxt = rt; pb_nxt = rd_r[95:0];
          ax_nxt = '0; state_nxt = S_AXIS;
        end else if (k_r + CW'(1) == cnt_r) begin
          state_nxt = S_OUT;
        end else begin
          ta_nxt = rt; pa_nxt = rd_r[95:0];
          k_nxt = k_r + CW'(1); state_nxt = S_RD;
        end
      end
      S_AXIS: begin
        neg_nxt = diff[32] ^ dtv[32];
        base_nxt = av;
        ov_nxt = dur[32] || dur == '0 || diff == '0 || dtv == '0;
        dreq.start = 1'b1;
        dreq.num = prod[63:0] + {32'd0, dur[32:1]};
        dreq.den = (dur == '0) ? 33'd1 : dur;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (ddone) begin
          unique case (ax_r)
            2'd0: px_nxt = ov_r ? av : satv;
            2'd1: py_nxt = ov_r ? av : satv;
            default: pz_nxt = ov_r ? av : satv;
          endcase
          if (ax_r == 2'd2) state_nxt = S_OUT;
          else begin
            ax_nxt = ax_r + 2'd1; state_nxt = S_AXIS;
          end
        end
      end
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  tthl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      old_r <= '0;
      cnt_r <= '0;
      span_r <= SpanReset;
      intv_r <= IntervalReset;
    end else begin
      state_r <= state_nxt;
      old_r <= old_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SPAN: span_r <= cfg_data;
          default: intv_r <= cfg_data;
        endcase
      end
    end
    k_r <= k_nxt;
    pa_r <= pa_nxt; pb_r <= pb_nxt; ta_r <= ta_nxt; tb_r <= tb_nxt;
    ax_r <= ax_nxt;
    neg_r <= neg_nxt;
    base_r <= base_nxt;
    px_r <= px_nxt; py_r <= py_nxt; pz_r <= pz_nxt;
    lost_r <= lost_nxt;
    ov_r <= ov_nxt;
    if (state_r == S_IDLE && in_valid) begin
      act_r <= in_action; t_r <= in_time_stamp; pres_r <= in_target_present;
      lx_r <= in_live_x; ly_r <= in_live_y; lz_r <= in_live_z;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_pos_x = px_r;
  assign out_pos_y = py_r;
  assign out_pos_z = pz_r;
  assign out_target_lost = lost_r;
  assign out_entry_count = cnt_r;

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: regression bench for timestamped_track_history_lerp
// Drives ticks, queries and clears with random gaps and stalls, predicts each
// result beat from a local copy of the history ring and compares field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tthl_pkg::*;

  localparam int Depth = HistDepthDef;
  localparam int GapMax = 17;
  localparam int IdleLimit = 20000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               lost;
    logic [4:0]         count;
  } track_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = ACT_TICK;
  logic [31:0] in_time_stamp = '0;
  logic in_target_present = 1'b0;
  logic signed [31:0] in_live_x = '0, in_live_y = '0, in_live_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_target_lost;
  logic [4:0] out_entry_count;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_SPAN;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  timestamped_track_history_lerp u_dut (.*);

  // predictor state
  logic [31:0] span_q, interval_q;
  logic [31:0] ring_t [Depth];
  logic signed [31:0] ring_x [Depth], ring_y [Depth], ring_z [Depth];
  int unsigned head_q, fill_q;

  track_res_t pending_q[$];
  int errors = 0;
  int beats_out = 0;
  int queries_sent = 0;
  int idle_cycles = 0;
  bit hold_rx = 1'b0;
  int unsigned now_q = 0;
  longint unsigned drop_at = 0;

  // exact rounded line point, ties away from zero, saturated
  function automatic logic signed [31:0] lerp_axis(logic signed [31:0] a,
      logic signed [31:0] b, longint dt, longint dur);
    longint diff;
    bit neg;
    logic [127:0] md, mt, q;
    logic signed [127:0] r;
    diff = longint'(b) - longint'(a);
    if (dur <= 0 || diff == 0 || dt == 0) return a;
    neg = (diff < 0) ^ (dt < 0);
    md = (diff < 0) ? -diff : diff;
    mt = (dt < 0) ? -dt : dt;
    q = (md * mt + dur / 2) / dur;
    if (q > 128'h2_0000_0000) return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    r = neg ? $signed({{96{a[31]}}, a}) - $signed(q) : $signed({{96{a[31]}}, a}) + $signed(q);
    if (r > 128'sh7fff_ffff) return 32'sh7fff_ffff;
    if (r < -128'sh8000_0000) return 32'sh8000_0000;
    return r[31:0];
  endfunction

  function automatic int unsigned slot(int unsigned k);
    return (head_q + k) % Depth;
  endfunction

  function automatic void pair_answer(int unsigned ka, int unsigned kb, logic [31:0] t,
                                      ref track_res_t r);
    longint dt, dur;
    int unsigned sa, sb;
    sa = slot(ka);
    sb = slot(kb);
    dt = longint'(t) - longint'(ring_t[sa]);
    dur = longint'(ring_t[sb]) - longint'(ring_t[sa]);
    r.x = lerp_axis(ring_x[sa], ring_x[sb], dt, dur);
    r.y = lerp_axis(ring_y[sa], ring_y[sb], dt, dur);
    r.z = lerp_axis(ring_z[sa], ring_z[sb], dt, dur);
  endfunction

  function automatic track_res_t track_step(logic [1:0] act, logic [31:0] t, logic pres,
      logic signed [31:0] lx, logic signed [31:0] ly, logic signed [31:0] lz);
    track_res_t r;
    bit want, hit;
    int unsigned s;
    r = '0;
    if (act == ACT_TICK) begin
      while (fill_q > 0 && longint'(t) - longint'(span_q) > longint'(ring_t[head_q])) begin
        head_q = (head_q + 1) % Depth;
        fill_q--;
      end
      want = fill_q == 0 ||
             longint'(t) > longint'(ring_t[slot(fill_q - 1)]) + longint'(interval_q);
      if (want && pres) begin
        if (fill_q >= Depth) begin
          head_q = (head_q + 1) % Depth;
          fill_q = Depth - 1;
        end
        s = slot(fill_q);
        ring_t[s] = t;
        ring_x[s] = lx;
        ring_y[s] = ly;
        ring_z[s] = lz;
        fill_q++;
      end else if (want) begin
        r.lost = 1'b1;
      end
    end else if (act == ACT_QUERY) begin
      if (fill_q == 0) begin
        if (pres) begin
          r.x = lx; r.y = ly; r.z = lz;
        end
      end else if (fill_q == 1) begin
        r.x = ring_x[head_q]; r.y = ring_y[head_q]; r.z = ring_z[head_q];
      end else begin
        hit = 1'b0;
        for (int unsigned k = 1; k < fill_q && !hit; k++) begin
          logic [31:0] ta, tb, lo, hi;
          ta = ring_t[slot(k - 1)];
          tb = ring_t[slot(k)];
          lo = ta < tb ? ta : tb;
          hi = ta < tb ? tb : ta;
          if (t >= lo && t <= hi) begin
            pair_answer(k - 1, k, t, r);
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (ring_t[slot(0)] > t) pair_answer(0, 1, t, r);
          else if (t > ring_t[slot(fill_q - 1)]) pair_answer(fill_q - 2, fill_q - 1, t, r);
        end
      end
    end else if (act == ACT_CLEAR) begin
      head_q = 0;
      fill_q = 0;
    end
    r.count = fill_q[4:0];
    return r;
  endfunction

  // drive one beat after a random gap; predict on acceptance
  task automatic send_item(logic [1:0] act, logic [31:0] t, logic pres,
      logic signed [31:0] lx, logic signed [31:0] ly, logic signed [31:0] lz,
      bit no_gap = 0);
    int gap;
    track_res_t exp_r;
    gap = no_gap ? 0 : $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, GapMax);
    repeat (gap) @(posedge clk);
    // valid was just dropped in this step; offer from the next edge
    if ($time == drop_at) @(posedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_time_stamp <= t;
    in_target_present <= pres;
    in_live_x <= lx;
    in_live_y <= ly;
    in_live_z <= lz;
    do @(posedge clk); while (in_stall);
    exp_r = track_step(act, t, pres, lx, ly, lz);
    pending_q = {pending_q, exp_r};
    if (act == ACT_QUERY) queries_sent++;
    in_valid <= 1'b0;
    drop_at = $time;
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPAN) span_q = val; else interval_q = val;
  endtask

  function automatic logic signed [31:0] rnd_pos();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 4000)) - 2000;
      default: return $urandom;
    endcase
  endfunction

  // tick at time t with random positions, target present unless pres is cleared
  task automatic tick_at(int unsigned t, bit pres = 1);
    send_item(ACT_TICK, t, pres, rnd_pos(), rnd_pos(), rnd_pos());
  endtask

  task automatic test_directed();
    // empty-history queries: live and absent
    send_item(ACT_QUERY, 32'd5, 1'b1, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd7);
    send_item(ACT_QUERY, 32'd5, 1'b0, 32'sd1, 32'sd2, 32'sd3);
    // lost on first tick
    send_item(ACT_TICK, 32'd100, 1'b0, 32'sd1, 32'sd1, 32'sd1);
    // single entry, then pairs with saturating extremes
    send_item(ACT_TICK, 32'd100, 1'b1, 32'sh8000_0000, 32'sd0, 32'sh7fff_ffff);
    send_item(ACT_QUERY, 32'd0, 1'b1, 32'sd9, 32'sd9, 32'sd9);
    send_item(ACT_TICK, 32'd200, 1'b1, 32'sd5, 32'sd5, 32'sd5);   // too soon
    send_item(ACT_TICK, 32'd500, 1'b1, 32'sh7fff_ffff, 32'sd3, 32'sh8000_0000);
    send_item(ACT_TICK, 32'd900, 1'b1, 32'sd0, -32'sd3, 32'sd0);
    send_item(ACT_QUERY, 32'd0, 1'b0, 0, 0, 0);          // extrapolate before
    send_item(ACT_QUERY, 32'd300, 1'b0, 0, 0, 0);        // inside first pair
    send_item(ACT_QUERY, 32'd500, 1'b0, 0, 0, 0);        // shared boundary
    send_item(ACT_QUERY, 32'hffff_ffff, 1'b0, 0, 0, 0);  // extrapolate after, saturate
    send_item(ACT_QUERY, 32'd700, 1'b0, 0, 0, 0);        // tie rounding
    send_item(ACT_TICK, 32'd3000, 1'b0, 0, 0, 0);        // lost, FIFO kept
    send_item(ACT_TICK, 32'd4500, 1'b1, 32'sd1, 32'sd2, 32'sd3); // ages out
    send_item(ACT_NONE, 32'hffff_ffff, 1'b1, 32'sd1, 32'sd1, 32'sd1);
    send_item(ACT_CLEAR, 32'd0, 1'b1, 32'sd1, 32'sd1, 32'sd1);
    // fill past depth to force oldest drop
    write_reg(CFG_SPAN, 32'hffff_ffff);
    write_reg(CFG_INTERVAL, 32'd1);
    for (int i = 0; i < Depth + 3; i++) tick_at(10 + 3 * i);
    send_item(ACT_QUERY, 32'd40, 1'b0, 0, 0, 0);
    send_item(ACT_TICK, 32'hffff_ffff, 1'b1, 32'sd4, 32'sd4, 32'sd4);
    send_item(ACT_CLEAR, 32'd0, 1'b0, 0, 0, 0);
  endtask

  // well-formed tracks with random content, plus some noise
  task automatic test_random(int items, logic [31:0] span, logic [31:0] ivl);
    int unsigned t;
    write_reg(CFG_SPAN, span);
    write_reg(CFG_INTERVAL, ivl);
    t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 5000);
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(0, 19))
        0: send_item(ACT_CLEAR, $urandom, $urandom_range(0, 1), rnd_pos(), rnd_pos(), rnd_pos());
        1: send_item(ACT_NONE, $urandom, $urandom_range(0, 1), rnd_pos(), rnd_pos(), rnd_pos());
        2, 3, 4, 5, 6, 7: send_item(ACT_QUERY,
               $urandom_range(0, 4) == 0 ? $urandom : t - $urandom_range(0, 6000) + 1000,
               $urandom_range(0, 1), rnd_pos(), rnd_pos(), rnd_pos());
        default: begin
          t = t + $urandom_range(0, 2 * (ivl > 2000 ? 2000 : ivl) + 10);
          if ($urandom_range(0, 30) == 0) t = $urandom;
          tick_at(t, $urandom_range(0, 9) != 0);
        end
      endcase
    end
  endtask

  // receiver goes quiet while the sender keeps offering
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        repeat (1500) @(posedge clk);
        hold_rx = 1'b0;
      end
      for (int i = 0; i < 6; i++) tick_at(20000 + 400 * i);
    join
    send_item(ACT_QUERY, 32'd21000, 1'b1, 0, 0, 0, 1);
  endtask

  // result side: random stalls, checks each beat
  initial begin
    int st;
    track_res_t exp_r;
    forever begin
      st = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, GapMax);
      if (st != 0 || hold_rx) begin
        out_stall <= 1'b1;
        while (st > 0 || hold_rx) begin
          @(posedge clk);
          if (st > 0) st--;
        end
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      beats_out++;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_pos_x !== exp_r.x) begin
          $error("pos_x exp %0d got %0d", exp_r.x, out_pos_x); errors++;
        end
        if (out_pos_y !== exp_r.y) begin
          $error("pos_y exp %0d got %0d", exp_r.y, out_pos_y); errors++;
        end
        if (out_pos_z !== exp_r.z) begin
          $error("pos_z exp %0d got %0d", exp_r.z, out_pos_z); errors++;
        end
        if (out_target_lost !== exp_r.lost) begin
          $error("target_lost exp %0d got %0d", exp_r.lost, out_target_lost); errors++;
        end
        if (out_entry_count !== exp_r.count) begin
          $error("entry_count exp %0d got %0d", exp_r.count, out_entry_count); errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    span_q = SpanReset;
    interval_q = IntervalReset;
    head_q = 0;
    fill_q = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(200, SpanReset, IntervalReset);
    test_random(150, 32'd0, 32'hffff_ffff);
    test_random(150, 32'd2000, 32'd1);
    test_random(100, 32'hffff_ffff, 32'd50);
    drain();
    $display("Covered %0d result beats, %0d queries, over five register settings.",
             beats_out, queries_sent);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
